/* hdl/closest_point_on_polyline_assert.svh */
// Assertion macros used by the closest point search controller.
`ifndef CLOSEST_POINT_ON_POLYLINE_ASSERT_SVH
`define CLOSEST_POINT_ON_POLYLINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cpp_pkg.sv */
// Shared constants, command codes and control structures of the closest point search.
package cpp_pkg;

	// Coordinate and intermediate widths.
	localparam int COORD_BITS = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int MUL_W      = DIFF_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int LEN_W      = 2 * DIFF_W;
	localparam int Q_W        = DIFF_W;
	localparam int NUM_W      = Q_W + LEN_W;
	localparam int DIST_W     = 64;
	localparam int CNT_W      = $clog2(Q_W + 1);

	// Configuration port.
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_QUERY_X = 1'd0;
	localparam cfg_idx_t REG_QUERY_Y = 1'd1;

	// Operand pairs of the shared multiplier.
	typedef logic [3:0] mul_sel_t;
	localparam mul_sel_t MUL_DXDX   = 4'd0;
	localparam mul_sel_t MUL_DYDY   = 4'd1;
	localparam mul_sel_t MUL_PXDX   = 4'd2;
	localparam mul_sel_t MUL_PYDY   = 4'd3;
	localparam mul_sel_t MUL_ADX_LO = 4'd4;
	localparam mul_sel_t MUL_ADX_HI = 4'd5;
	localparam mul_sel_t MUL_ADY_LO = 4'd6;
	localparam mul_sel_t MUL_ADY_HI = 4'd7;
	localparam mul_sel_t MUL_EXEX   = 4'd8;
	localparam mul_sel_t MUL_EYEY   = 4'd9;

	// Destinations of the registered product.
	typedef logic [3:0] acc_op_t;
	localparam acc_op_t ACC_NONE     = 4'd0;
	localparam acc_op_t ACC_LEN_SET  = 4'd1;
	localparam acc_op_t ACC_LEN_ADD  = 4'd2;
	localparam acc_op_t ACC_DOT_SET  = 4'd3;
	localparam acc_op_t ACC_DOT_ADD  = 4'd4;
	localparam acc_op_t ACC_NX_SET   = 4'd5;
	localparam acc_op_t ACC_NX_ADDHI = 4'd6;
	localparam acc_op_t ACC_NY_SET   = 4'd7;
	localparam acc_op_t ACC_NY_ADDHI = 4'd8;
	localparam acc_op_t ACC_D2_SET   = 4'd9;
	localparam acc_op_t ACC_D2_ADD   = 4'd10;

	// Source of the candidate point.
	typedef logic [1:0] cand_sel_t;
	localparam cand_sel_t CAND_NONE = 2'd0;
	localparam cand_sel_t CAND_A    = 2'd1;
	localparam cand_sel_t CAND_B    = 2'd2;
	localparam cand_sel_t CAND_Q    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_edge;
		logic      calc_delta;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		cand_sel_t cand_sel;
		logic      calc_diff;
		logic      div_start;
		logic      update_best;
		logic      emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic degen;
		logic last;
		logic dot_le0;
		logic dot_ge_len;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

/* hdl/cpp_div.sv */
// Restoring divider, one quotient bit per cycle, for the projection quotient.
module cpp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cpp_pkg::NUM_W-1:0]  num,
	input  logic [cpp_pkg::LEN_W-1:0]  den,
	output logic                       busy,
	output logic [cpp_pkg::Q_W-1:0]    quot
);
	import cpp_pkg::*;

	logic [LEN_W-1:0] rem_q;
	logic [Q_W-1:0]   sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   trial_sub;
	logic             fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial     = {rem_q, sh_q[Q_W-1]};
	assign trial_sub = trial - {1'b0, den};
	assign fits      = (trial >= {1'b0, den});

	assign busy = (cnt_q != '0);
	assign quot = sh_q;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The upper dividend bits start as the remainder; the quotient replaces the low bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:Q_W];
			sh_q  <= num[Q_W-1:0];
		end else if (busy) begin
			rem_q <= fits ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], fits};
		end
	end

endmodule

/* hdl/cpp_datapath.sv */
// Datapath: edge registers, shared multiplier, projection dividers and best point tracking.
module cpp_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cpp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cpp_pkg::CFG_W-1:0]             cfg_data,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] end_y,
	input  logic                                  last_edge,
	input  cpp_pkg::cmd_t                         cmd,
	output cpp_pkg::status_t                      status,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic signed [cpp_pkg::COORD_BITS-1:0] best_x,
	output logic signed [cpp_pkg::COORD_BITS-1:0] best_y,
	output logic [cpp_pkg::DIST_W-1:0]            best_dist_sq,
	output logic                                  found
);
	import cpp_pkg::*;

	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	logic                         last_q;
	logic signed [DIFF_W-1:0]     dx_q, dy_q, pax_q, pay_q;
	logic [DIFF_W-1:0]            adx_q, ady_q;
	logic signed [MUL_W-1:0]      mul_a, mul_b;
	logic signed [PROD_W-1:0]     prod_q;
	logic [LEN_W-1:0]             len2_q;
	logic signed [PROD_W-1:0]     dot_q;
	logic [NUM_W-1:0]             numx_q, numy_q;
	logic [LEN_W-1:0]             d2acc_q;
	logic [Q_W-1:0]               quot_x, quot_y;
	logic                         busy_x, busy_y;
	logic signed [DIFF_W-1:0]     interp_x, interp_y;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [DIFF_W-1:0]     ex_q, ey_q;
	logic [DIST_W-1:0]            d2_sat;
	logic signed [COORD_BITS-1:0] best_px_q, best_py_q;
	logic [DIST_W-1:0]            best_d2_q;
	logic                         any_found_q;
	logic                         out_valid_q;

	// Query point registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUERY_X: qx_q <= cfg_data;
				REG_QUERY_Y: qy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge capture on an input transfer, then the edge and query offsets.
	always_ff @(posedge clk) begin
		if (cmd.load_edge) begin
			ax_q   <= start_x;
			ay_q   <= start_y;
			bx_q   <= end_x;
			by_q   <= end_y;
			last_q <= last_edge;
		end
		if (cmd.calc_delta) begin
			dx_q  <= {bx_q[COORD_BITS-1], bx_q} - {ax_q[COORD_BITS-1], ax_q};
			dy_q  <= {by_q[COORD_BITS-1], by_q} - {ay_q[COORD_BITS-1], ay_q};
			pax_q <= {qx_q[COORD_BITS-1], qx_q} - {ax_q[COORD_BITS-1], ax_q};
			pay_q <= {qy_q[COORD_BITS-1], qy_q} - {ay_q[COORD_BITS-1], ay_q};
		end
		adx_q <= dx_q[DIFF_W-1] ? -dx_q : dx_q;
		ady_q <= dy_q[DIFF_W-1] ? -dy_q : dy_q;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MUL_DXDX: begin
				mul_a = {dx_q[DIFF_W-1], dx_q};
				mul_b = {dx_q[DIFF_W-1], dx_q};
			end
			MUL_DYDY: begin
				mul_a = {dy_q[DIFF_W-1], dy_q};
				mul_b = {dy_q[DIFF_W-1], dy_q};
			end
			MUL_PXDX: begin
				mul_a = {pax_q[DIFF_W-1], pax_q};
				mul_b = {dx_q[DIFF_W-1], dx_q};
			end
			MUL_PYDY: begin
				mul_a = {pay_q[DIFF_W-1], pay_q};
				mul_b = {dy_q[DIFF_W-1], dy_q};
			end
			MUL_ADX_LO: begin
				mul_a = {1'b0, adx_q};
				mul_b = {1'b0, dot_q[Q_W-1:0]};
			end
			MUL_ADX_HI: begin
				mul_a = {1'b0, adx_q};
				mul_b = {1'b0, dot_q[LEN_W-1:Q_W]};
			end
			MUL_ADY_LO: begin
				mul_a = {1'b0, ady_q};
				mul_b = {1'b0, dot_q[Q_W-1:0]};
			end
			MUL_ADY_HI: begin
				mul_a = {1'b0, ady_q};
				mul_b = {1'b0, dot_q[LEN_W-1:Q_W]};
			end
			MUL_EXEX: begin
				mul_a = {ex_q[DIFF_W-1], ex_q};
				mul_b = {ex_q[DIFF_W-1], ex_q};
			end
			MUL_EYEY: begin
				mul_a = {ey_q[DIFF_W-1], ey_q};
				mul_b = {ey_q[DIFF_W-1], ey_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Registered product, then accumulation into the selected register.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LEN_SET:  len2_q  <= prod_q[LEN_W-1:0];
			ACC_LEN_ADD:  len2_q  <= len2_q + prod_q[LEN_W-1:0];
			ACC_DOT_SET:  dot_q   <= prod_q;
			ACC_DOT_ADD:  dot_q   <= dot_q + prod_q;
			ACC_NX_SET:   numx_q  <= {{Q_W{1'b0}}, prod_q[LEN_W-1:0]};
			ACC_NX_ADDHI: numx_q  <= numx_q + {prod_q[LEN_W-1:0], {Q_W{1'b0}}};
			ACC_NY_SET:   numy_q  <= {{Q_W{1'b0}}, prod_q[LEN_W-1:0]};
			ACC_NY_ADDHI: numy_q  <= numy_q + {prod_q[LEN_W-1:0], {Q_W{1'b0}}};
			ACC_D2_SET:   d2acc_q <= prod_q[LEN_W-1:0];
			ACC_D2_ADD:   d2acc_q <= d2acc_q + prod_q[LEN_W-1:0];
			default: ;
		endcase
	end

	// One divider per axis, both sharing the squared edge length.
	cpp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (numx_q),
		.den    (len2_q),
		.busy   (busy_x),
		.quot   (quot_x)
	);

	cpp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (numy_q),
		.den    (len2_q),
		.busy   (busy_y),
		.quot   (quot_y)
	);

	// Interpolated point: step from A toward B by the truncated quotient.
	assign interp_x = dx_q[DIFF_W-1] ? ({ax_q[COORD_BITS-1], ax_q} - $signed(quot_x))
	                                 : ({ax_q[COORD_BITS-1], ax_q} + $signed(quot_x));
	assign interp_y = dy_q[DIFF_W-1] ? ({ay_q[COORD_BITS-1], ay_q} - $signed(quot_y))
	                                 : ({ay_q[COORD_BITS-1], ay_q} + $signed(quot_y));

	// Candidate point and its offset from the query.
	always_ff @(posedge clk) begin
		case (cmd.cand_sel)
			CAND_A: begin
				cx_q <= ax_q;
				cy_q <= ay_q;
			end
			CAND_B: begin
				cx_q <= bx_q;
				cy_q <= by_q;
			end
			CAND_Q: begin
				cx_q <= interp_x[COORD_BITS-1:0];
				cy_q <= interp_y[COORD_BITS-1:0];
			end
			default: ;
		endcase
		if (cmd.calc_diff) begin
			ex_q <= {cx_q[COORD_BITS-1], cx_q} - {qx_q[COORD_BITS-1], qx_q};
			ey_q <= {cy_q[COORD_BITS-1], cy_q} - {qy_q[COORD_BITS-1], qy_q};
		end
	end

	// The squared distance saturates at all ones.
	assign d2_sat = (|d2acc_q[LEN_W-1:DIST_W]) ? {DIST_W{1'b1}} : d2acc_q[DIST_W-1:0];

	// Best point so far; the first candidate always wins, ties keep the earlier one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_px_q   <= '0;
			best_py_q   <= '0;
			best_d2_q   <= {DIST_W{1'b1}};
			any_found_q <= 1'b0;
		end else if (cmd.emit) begin
			best_px_q   <= '0;
			best_py_q   <= '0;
			best_d2_q   <= {DIST_W{1'b1}};
			any_found_q <= 1'b0;
		end else if (cmd.update_best) begin
			if (!any_found_q || (d2_sat < best_d2_q)) begin
				best_px_q <= cx_q;
				best_py_q <= cy_q;
				best_d2_q <= d2_sat;
			end
			any_found_q <= 1'b1;
		end
	end

	// Output register valid flag: set on emit, cleared by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			best_x       <= best_px_q;
			best_y       <= best_py_q;
			best_dist_sq <= best_d2_q;
			found        <= any_found_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the controller.
	always_comb begin
		status.degen      = (ax_q == bx_q) && (ay_q == by_q);
		status.last       = last_q;
		status.dot_le0    = dot_q[PROD_W-1] || (dot_q == '0);
		status.dot_ge_len = (dot_q >= $signed({{(PROD_W-LEN_W){1'b0}}, len2_q}));
		status.div_busy   = busy_x || busy_y;
		status.out_free   = !out_valid_q || !out_stall;
	end

endmodule

/* hdl/cpp_ctrl.sv */
// Controller: sequences one edge at a time through the datapath.
module cpp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  cpp_pkg::status_t status,
	output cpp_pkg::cmd_t    cmd
);
	import cpp_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_DELTA     = 5'd1;
	localparam logic [4:0] S_LEN_A     = 5'd2;
	localparam logic [4:0] S_LEN_B     = 5'd3;
	localparam logic [4:0] S_DOT_A     = 5'd4;
	localparam logic [4:0] S_DOT_B     = 5'd5;
	localparam logic [4:0] S_DOT_C     = 5'd6;
	localparam logic [4:0] S_CLASS     = 5'd7;
	localparam logic [4:0] S_NUM_A     = 5'd8;
	localparam logic [4:0] S_NUM_B     = 5'd9;
	localparam logic [4:0] S_NUM_C     = 5'd10;
	localparam logic [4:0] S_NUM_D     = 5'd11;
	localparam logic [4:0] S_NUM_E     = 5'd12;
	localparam logic [4:0] S_DIV_START = 5'd13;
	localparam logic [4:0] S_DIV_WAIT  = 5'd14;
	localparam logic [4:0] S_INTERP    = 5'd15;
	localparam logic [4:0] S_DIFF      = 5'd16;
	localparam logic [4:0] S_D2_A      = 5'd17;
	localparam logic [4:0] S_D2_B      = 5'd18;
	localparam logic [4:0] S_D2_C      = 5'd19;
	localparam logic [4:0] S_UPDATE    = 5'd20;
	localparam logic [4:0] S_FINISH    = 5'd21;

	logic [4:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		cmd.load_edge   = 1'b0;
		cmd.calc_delta  = 1'b0;
		cmd.mul_sel     = MUL_DXDX;
		cmd.acc_op      = ACC_NONE;
		cmd.cand_sel    = CAND_NONE;
		cmd.calc_diff   = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.update_best = 1'b0;
		cmd.emit        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_edge = 1'b1;
					state_d       = S_DELTA;
				end
			end
			S_DELTA: begin
				cmd.calc_delta = 1'b1;
				state_d        = status.degen ? S_FINISH : S_LEN_A;
			end
			S_LEN_A: begin
				cmd.mul_sel = MUL_DXDX;
				state_d     = S_LEN_B;
			end
			S_LEN_B: begin
				cmd.acc_op  = ACC_LEN_SET;
				cmd.mul_sel = MUL_DYDY;
				state_d     = S_DOT_A;
			end
			S_DOT_A: begin
				cmd.acc_op  = ACC_LEN_ADD;
				cmd.mul_sel = MUL_PXDX;
				state_d     = S_DOT_B;
			end
			S_DOT_B: begin
				cmd.acc_op  = ACC_DOT_SET;
				cmd.mul_sel = MUL_PYDY;
				state_d     = S_DOT_C;
			end
			S_DOT_C: begin
				cmd.acc_op = ACC_DOT_ADD;
				state_d    = S_CLASS;
			end
			// Clamp to an endpoint, or go on to interpolate.
			S_CLASS: begin
				if (status.dot_le0) begin
					cmd.cand_sel = CAND_A;
					state_d      = S_DIFF;
				end else if (status.dot_ge_len) begin
					cmd.cand_sel = CAND_B;
					state_d      = S_DIFF;
				end else begin
					state_d = S_NUM_A;
				end
			end
			S_NUM_A: begin
				cmd.mul_sel = MUL_ADX_LO;
				state_d     = S_NUM_B;
			end
			S_NUM_B: begin
				cmd.acc_op  = ACC_NX_SET;
				cmd.mul_sel = MUL_ADX_HI;
				state_d     = S_NUM_C;
			end
			S_NUM_C: begin
				cmd.acc_op  = ACC_NX_ADDHI;
				cmd.mul_sel = MUL_ADY_LO;
				state_d     = S_NUM_D;
			end
			S_NUM_D: begin
				cmd.acc_op  = ACC_NY_SET;
				cmd.mul_sel = MUL_ADY_HI;
				state_d     = S_NUM_E;
			end
			S_NUM_E: begin
				cmd.acc_op = ACC_NY_ADDHI;
				state_d    = S_DIV_START;
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (!status.div_busy) begin
					state_d = S_INTERP;
				end
			end
			S_INTERP: begin
				cmd.cand_sel = CAND_Q;
				state_d      = S_DIFF;
			end
			S_DIFF: begin
				cmd.calc_diff = 1'b1;
				state_d       = S_D2_A;
			end
			S_D2_A: begin
				cmd.mul_sel = MUL_EXEX;
				state_d     = S_D2_B;
			end
			S_D2_B: begin
				cmd.acc_op  = ACC_D2_SET;
				cmd.mul_sel = MUL_EYEY;
				state_d     = S_D2_C;
			end
			S_D2_C: begin
				cmd.acc_op = ACC_D2_ADD;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update_best = 1'b1;
				state_d         = S_FINISH;
			end
			// On the last edge, wait for room in the output register.
			S_FINISH: begin
				if (!status.last) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`include "closest_point_on_polyline_assert.svh"

	`CPP_ASSERT_SAME(a_emit_out_free, cmd.emit, status.out_free, "result overwrote an untaken result")
	`CPP_ASSERT_NEXT(a_div_start_busy, cmd.div_start, status.div_busy, "divider did not start")
	`CPP_ASSERT_SAME(a_interp_div_idle, cmd.cand_sel == CAND_Q, !status.div_busy, "quotient used early")
	`CPP_ASSERT_NEXT(a_degen_skip, (state_q == S_DELTA) && status.degen, state_q == S_FINISH, "zero-length edge not skipped")

endmodule

/* hdl/closest_point_on_polyline.sv */
// Top level of the closest point on polyline search.
//
// Edges of a polyline arrive on the input channel (in_valid, in_stall) as endpoint
// pairs in signed Q16.16, the final edge flagged by last_edge. The query point is
// written beforehand through cfg_we, cfg_index and cfg_data while the block is idle.
// One edge is processed at a time; in_stall is high until the edge is finished.
// An edge clamped to an endpoint goes through the offset, squared length, dot product,
// distance, update and finish steps; an interpolated edge also forms the numerators
// and waits for the two one-bit-per-cycle dividers of the projection quotient. A
// zero-length edge goes straight to the finish step. The products are formed one
// after another in the shared multiplier. On the last edge the best point, its
// squared distance and the found flag are loaded into the output register together
// with out_valid in the finish step; the search state then clears for the next
// polyline. A stalled result stays in the output register, and the next edges are
// still taken; only the next last edge waits until the result has been transferred.
// Reset clears the query point to the origin, empties the output register and the
// best point state.
module closest_point_on_polyline (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cpp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cpp_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [cpp_pkg::COORD_BITS-1:0] end_y,
	input  logic                                  last_edge,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cpp_pkg::COORD_BITS-1:0] best_x,
	output logic signed [cpp_pkg::COORD_BITS-1:0] best_y,
	output logic [cpp_pkg::DIST_W-1:0]            best_dist_sq,
	output logic                                  found
);
	import cpp_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	cpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic, best point state and output register.
	cpp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.last_edge    (last_edge),
		.cmd          (cmd),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.best_x       (best_x),
		.best_y       (best_y),
		.best_dist_sq (best_dist_sq),
		.found        (found)
	);

endmodule
